/* hw/rtl/pdpr_pkg.sv */
// Shared constants and types for the Pelco-D position rewriter.
// Used by pdpr_angle_fix and pelco_d_position_rewriter; depends on nothing else.
package pdpr_pkg;

    localparam int FRAME_LEN = 7;
    localparam int BYTE_W    = 8;
    localparam int OFFSET_W  = 17;
    localparam int ANGLE_W   = 17;
    localparam int KIND_W    = 2;
    localparam int FILL_W    = 3;

    // Internal width for offset arithmetic: raw angle minus any 17-bit offset
    // plus or minus a few full turns.
    localparam int CALC_W = 20;

    localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_PAN_RESP  = 8'h59;
    localparam logic [BYTE_W-1:0] CMD_TILT_RESP = 8'h5B;

    // Angles are in hundredths of a degree.
    localparam logic signed [CALC_W-1:0] HALF_TURN   = 20'sd18000;
    localparam logic signed [CALC_W-1:0] FULL_TURN   = 20'sd36000;
    localparam logic signed [CALC_W-1:0] TWO_TURNS   = 20'sd72000;
    localparam logic signed [CALC_W-1:0] THREE_TURNS = 20'sd108000;
    localparam logic signed [CALC_W-1:0] FOUR_TURNS  = 20'sd144000;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TILT = 2'd2;

    localparam logic REG_PAN_OFFSET  = 1'b0;
    localparam logic REG_TILT_OFFSET = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;

    // Rewritten position bytes and checksum for one frame.
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [ANGLE_W-1:0] angle;
        byte_t                     pos_hi;
        byte_t                     pos_lo;
        byte_t                     csum;
    } pdpr_fix_t;

endpackage

/* hw/rtl/pdpr_angle_fix.sv */
// Offset correction of pan and tilt position responses, with checksum rebuild.
// Purely combinational; depends on pdpr_pkg.
module pdpr_angle_fix (
    input  pdpr_pkg::byte_t                           addr_byte,
    input  pdpr_pkg::byte_t                           cmd1_byte,
    input  pdpr_pkg::byte_t                           cmd2_byte,
    input  pdpr_pkg::byte_t                           data1_byte,
    input  pdpr_pkg::byte_t                           data2_byte,
    input  pdpr_pkg::byte_t                           csum_byte,
    input  logic signed [pdpr_pkg::OFFSET_W-1:0]      pan_offset,
    input  logic signed [pdpr_pkg::OFFSET_W-1:0]      tilt_offset,
    output pdpr_pkg::pdpr_fix_t                       fix
);
    import pdpr_pkg::*;

    localparam logic signed [CALC_W-1:0] NEG_HALF   = -HALF_TURN;
    localparam logic signed [CALC_W-1:0] LIM_ONE    = HALF_TURN + FULL_TURN;
    localparam logic signed [CALC_W-1:0] LIM_TWO    = HALF_TURN + TWO_TURNS;
    localparam logic signed [CALC_W-1:0] LIM_THREE  = HALF_TURN + THREE_TURNS;

    logic signed [CALC_W-1:0] raw;
    logic signed [CALC_W-1:0] pan_diff;
    logic signed [CALC_W-1:0] pan_wrapped;
    logic signed [CALC_W-1:0] tilt_pre;
    logic signed [CALC_W-1:0] tilt_diff;
    logic signed [CALC_W-1:0] tilt_wrapped;
    logic signed [CALC_W-1:0] tilt_enc;
    logic [15:0]              enc;
    logic [KIND_W-1:0]        kind_sel;
    logic signed [ANGLE_W-1:0] angle_sel;
    byte_t                    new_hi;
    byte_t                    new_lo;
    byte_t                    new_csum;

    assign raw       = CALC_W'(signed'({1'b0, data1_byte, data2_byte}));
    assign pan_diff  = raw - CALC_W'(pan_offset);

    // Floor modulo into 0..35999; the difference lies within -65535..131071.
    always_comb
    begin
        if (pan_diff < 0)
        begin
            pan_wrapped = (pan_diff + FULL_TURN >= 0) ? pan_diff + FULL_TURN
                                                      : pan_diff + TWO_TURNS;
        end
        else if (pan_diff < FULL_TURN)
        begin
            pan_wrapped = pan_diff;
        end
        else if (pan_diff < TWO_TURNS)
        begin
            pan_wrapped = pan_diff - FULL_TURN;
        end
        else if (pan_diff < THREE_TURNS)
        begin
            pan_wrapped = pan_diff - TWO_TURNS;
        end
        else
        begin
            pan_wrapped = pan_diff - THREE_TURNS;
        end
    end

    // Raw tilt above half a turn, up to a full turn, means a negative angle.
    assign tilt_pre  = (raw > HALF_TURN && raw <= FULL_TURN) ? raw - FULL_TURN : raw;
    assign tilt_diff = tilt_pre - CALC_W'(tilt_offset);

    // Values below the range wrap up to at least -18000, values above wrap down
    // to at most 18000, so both ends of the range stay reachable.
    always_comb
    begin
        if (tilt_diff < NEG_HALF)
        begin
            tilt_wrapped = (tilt_diff + FULL_TURN >= NEG_HALF) ? tilt_diff + FULL_TURN
                                                               : tilt_diff + TWO_TURNS;
        end
        else if (tilt_diff <= HALF_TURN)
        begin
            tilt_wrapped = tilt_diff;
        end
        else if (tilt_diff <= LIM_ONE)
        begin
            tilt_wrapped = tilt_diff - FULL_TURN;
        end
        else if (tilt_diff <= LIM_TWO)
        begin
            tilt_wrapped = tilt_diff - TWO_TURNS;
        end
        else if (tilt_diff <= LIM_THREE)
        begin
            tilt_wrapped = tilt_diff - THREE_TURNS;
        end
        else
        begin
            tilt_wrapped = tilt_diff - FOUR_TURNS;
        end
    end

    assign tilt_enc = (tilt_wrapped < 0) ? tilt_wrapped + FULL_TURN : tilt_wrapped;

    always_comb
    begin
        case (cmd2_byte)
            CMD_PAN_RESP:
            begin
                kind_sel  = KIND_PAN;
                angle_sel = pan_wrapped[ANGLE_W-1:0];
                enc       = pan_wrapped[15:0];
            end
            CMD_TILT_RESP:
            begin
                kind_sel  = KIND_TILT;
                angle_sel = tilt_wrapped[ANGLE_W-1:0];
                enc       = tilt_enc[15:0];
            end
            default:
            begin
                kind_sel  = KIND_NONE;
                angle_sel = '0;
                enc       = {data1_byte, data2_byte};
            end
        endcase
    end

    assign new_hi = enc[15:8];
    assign new_lo = enc[7:0];

    // Frames that are not rewritten keep their original checksum.
    assign new_csum = (kind_sel == KIND_NONE) ? csum_byte
                    : byte_t'(addr_byte + cmd1_byte + cmd2_byte + new_hi + new_lo);

    assign fix = '{kind: kind_sel, angle: angle_sel, pos_hi: new_hi, pos_lo: new_lo,
                   csum: new_csum};

endmodule

/* hw/rtl/pelco_d_position_rewriter.sv */
// Top level of the Pelco-D position rewriter: frame sync, frame register and
// byte output buffer. Depends on pdpr_pkg and pdpr_angle_fix.
//
// Usage: received bytes arrive on in_valid/in_stall with rx_byte, one byte per
// transfer. Six bytes fill a window. When they and the next byte form a frame
// that starts with 0xFF and whose last byte is the sum of bytes 1 to 5, it is
// taken; otherwise the oldest byte is dropped and the window waits for one more.
// A taken frame leaves on out_valid/out_stall as seven transfers of tx_byte,
// with last_byte on the seventh; angle_kind and angle_value hold the corrected
// pan or tilt angle on every byte of the frame.
// A completing transfer loads the frame register; the frame moves to the output
// buffer once that is empty or sends its last byte. While out_stall stays low,
// throughput is one input byte per cycle, sustained, and one output byte per
// cycle; a frame register between the window and the output buffer lets the
// next frame complete while the previous one drains. When the receiver stalls,
// the output buffer holds; in_stall rises only when the window is one byte
// short of a frame and the frame register is occupied. Write offsets on
// cfg_we/cfg_index/cfg_data only while the block is idle; it does not enforce
// this. Reset empties the window and both buffers and zeroes both offsets.
module pelco_d_position_rewriter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  pdpr_pkg::byte_t                          rx_byte,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output pdpr_pkg::byte_t                          tx_byte,
    output logic                                     last_byte,
    output logic [pdpr_pkg::KIND_W-1:0]              angle_kind,
    output logic signed [pdpr_pkg::ANGLE_W-1:0]      angle_value,
    input  logic                                     cfg_we,
    input  logic                                     cfg_index,
    input  logic [pdpr_pkg::OFFSET_W-1:0]            cfg_data
);
    import pdpr_pkg::*;

    localparam int WIN_LEN = FRAME_LEN - 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
    localparam logic [FILL_W-1:0] IDX_LAST  = FILL_W'(FRAME_LEN - 1);

    logic signed [OFFSET_W-1:0] pan_offset_reg;
    logic signed [OFFSET_W-1:0] tilt_offset_reg;

    byte_t             win_reg [WIN_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    byte_t             frame_reg [FRAME_LEN];
    logic              frame_valid_reg;

    byte_t             out_bytes_reg [FRAME_LEN];
    logic [KIND_W-1:0] out_kind_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic [FILL_W-1:0] out_idx_reg;
    logic              out_busy_reg;

    logic              in_xfer;
    logic              out_xfer;
    logic              out_last_xfer;
    logic              frame_move;
    logic              frame_done;
    logic              sync_ok;
    byte_t             mid_sum;
    pdpr_fix_t         fix;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_offset_reg  <= '0;
            tilt_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAN_OFFSET:  pan_offset_reg  <= signed'(cfg_data);
                REG_TILT_OFFSET: tilt_offset_reg <= signed'(cfg_data);
                default:         ;
            endcase
        end
    end

    assign out_valid     = out_busy_reg;
    assign out_xfer      = out_busy_reg && !out_stall;
    assign out_last_xfer = out_xfer && (out_idx_reg == IDX_LAST);
    assign frame_move    = frame_valid_reg && (!out_busy_reg || out_last_xfer);

    assign in_stall = (fill_reg == FILL_FULL) && frame_valid_reg && !frame_move;
    assign in_xfer  = in_valid && !in_stall;

    assign mid_sum    = byte_t'(win_reg[1] + win_reg[2] + win_reg[3]
                                + win_reg[4] + win_reg[5]);
    assign sync_ok    = (win_reg[0] == SYNC_BYTE) && (mid_sum == rx_byte);
    assign frame_done = in_xfer && (fill_reg == FILL_FULL) && sync_ok;

    always_comb
    begin
        fill_next = fill_reg;
        if (in_xfer)
        begin
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + 1'b1;
            end
            else if (sync_ok)
            begin
                fill_next = '0;
            end
        end
    end

    // Window contents; a failed check slides the window by one byte.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (fill_reg != FILL_FULL)
            begin
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    if (fill_reg == FILL_W'(i))
                    begin
                        win_reg[i] <= rx_byte;
                    end
                end
            end
            else if (!sync_ok)
            begin
                for (int i = 0; i < WIN_LEN - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN_LEN-1] <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                frame_reg[i] <= win_reg[i];
            end
            frame_reg[FRAME_LEN-1] <= rx_byte;
        end
    end

    pdpr_angle_fix u_angle_fix (
        .addr_byte   (frame_reg[1]),
        .cmd1_byte   (frame_reg[2]),
        .cmd2_byte   (frame_reg[3]),
        .data1_byte  (frame_reg[4]),
        .data2_byte  (frame_reg[5]),
        .csum_byte   (frame_reg[6]),
        .pan_offset  (pan_offset_reg),
        .tilt_offset (tilt_offset_reg),
        .fix         (fix)
    );

    // Output buffer payload: loaded from the frame register, then shifted out.
    always_ff @(posedge clk)
    begin
        if (frame_move)
        begin
            out_bytes_reg[0] <= frame_reg[0];
            out_bytes_reg[1] <= frame_reg[1];
            out_bytes_reg[2] <= frame_reg[2];
            out_bytes_reg[3] <= frame_reg[3];
            out_bytes_reg[4] <= fix.pos_hi;
            out_bytes_reg[5] <= fix.pos_lo;
            out_bytes_reg[6] <= fix.csum;
            out_kind_reg     <= fix.kind;
            out_angle_reg    <= fix.angle;
        end
        else if (out_xfer)
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                out_bytes_reg[i] <= out_bytes_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            frame_valid_reg <= 1'b0;
            out_busy_reg    <= 1'b0;
            out_idx_reg     <= '0;
        end
        else
        begin
            fill_reg <= fill_next;

            if (frame_done)
            begin
                frame_valid_reg <= 1'b1;
            end
            else if (frame_move)
            begin
                frame_valid_reg <= 1'b0;
            end

            if (frame_move)
            begin
                out_busy_reg <= 1'b1;
                out_idx_reg  <= '0;
            end
            else if (out_last_xfer)
            begin
                out_busy_reg <= 1'b0;
                out_idx_reg  <= '0;
            end
            else if (out_xfer)
            begin
                out_idx_reg <= out_idx_reg + 1'b1;
            end
        end
    end

    assign tx_byte     = out_bytes_reg[0];
    assign last_byte   = (out_idx_reg == IDX_LAST);
    assign angle_kind  = out_kind_reg;
    assign angle_value = out_angle_reg;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("window fill count out of range");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (fill_reg == FILL_FULL) && frame_valid_reg)
        else $error("input stalled while the window cannot complete a frame");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_busy_reg && !out_last_xfer |=> out_busy_reg)
        else $error("output frame dropped before its last byte");

    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame_move |=> out_busy_reg && (out_idx_reg == '0))
        else $error("frame load did not start at the first byte");

    a_no_frame_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> !frame_valid_reg || frame_move)
        else $error("completed frame overwrote a pending frame");
`endif

endmodule

/* verif/pelco_d_position_rewriter_checker.sv */
// Checker for the Pelco-D position rewriter: predicts the outgoing frame bytes
// from observed input and register transfers and compares each output transfer.
// Depends on pdpr_pkg for port types, command codes and register indexes.
module pelco_d_position_rewriter_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  pdpr_pkg::byte_t                     rx_byte,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  pdpr_pkg::byte_t                     tx_byte,
    input  logic                                last_byte,
    input  logic [pdpr_pkg::KIND_W-1:0]         angle_kind,
    input  logic signed [pdpr_pkg::ANGLE_W-1:0] angle_value,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [pdpr_pkg::OFFSET_W-1:0]       cfg_data,
    output int                                  mismatches,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdpr_pkg::*;

    localparam int TURN      = 36000;
    localparam int HALF_TURN_CENTI = 18000;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        byte_t                     tx;
        logic                      last;
        logic [KIND_W-1:0]         kind;
        logic signed [ANGLE_W-1:0] angle;
    } tx_beat_t;

    byte_t    rx_window [FRAME_LEN];
    int       fill;
    int       pan_off;
    int       tilt_off;
    tx_beat_t tx_beats_due [$];

    // Shifts one received byte into the window and queues the seven outgoing
    // bytes when the window holds a frame that passes the sync and sum test.
    function automatic void accept_rx_byte(input byte_t b);
        byte_t             frame [FRAME_LEN];
        logic [7:0]        csum;
        int                raw;
        int                ang;
        int                enc;
        int                i;
        logic [KIND_W-1:0] kind;
        tx_beat_t          beat;

        rx_window[fill] = b;
        fill++;
        if (fill < FRAME_LEN)
            return;
        csum = rx_window[1] + rx_window[2] + rx_window[3] + rx_window[4] + rx_window[5];
        if (rx_window[0] != SYNC_BYTE || csum != rx_window[6])
        begin
            for (i = 0; i < FRAME_LEN - 1; i++)
                rx_window[i] = rx_window[i + 1];
            rx_window[FRAME_LEN - 1] = '0;
            fill = FRAME_LEN - 1;
            return;
        end

        frame = rx_window;
        for (i = 0; i < FRAME_LEN; i++)
            rx_window[i] = '0;
        fill = 0;

        raw  = {frame[4], frame[5]};
        kind = KIND_NONE;
        ang  = 0;
        enc  = 0;
        if (frame[3] == CMD_PAN_RESP)
        begin
            ang = (raw - pan_off) % TURN;
            if (ang < 0)
                ang += TURN;
            enc  = ang;
            kind = KIND_PAN;
        end
        else if (frame[3] == CMD_TILT_RESP)
        begin
            // The upper half turn reads as a negative tilt before correction.
            ang = raw;
            if (ang > HALF_TURN_CENTI && ang <= TURN)
                ang -= TURN;
            ang -= tilt_off;
            while (ang < -HALF_TURN_CENTI)
                ang += TURN;
            while (ang > HALF_TURN_CENTI)
                ang -= TURN;
            enc  = (ang < 0) ? ang + TURN : ang;
            kind = KIND_TILT;
        end
        if (kind != KIND_NONE)
        begin
            frame[4] = enc[15:8];
            frame[5] = enc[7:0];
            frame[6] = frame[1] + frame[2] + frame[3] + frame[4] + frame[5];
        end

        for (i = 0; i < FRAME_LEN; i++)
        begin
            beat.tx    = frame[i];
            beat.last  = (i == FRAME_LEN - 1);
            beat.kind  = kind;
            beat.angle = ang[ANGLE_W-1:0];
            tx_beats_due.push_back(beat);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tx_beat_t want;
        int       i;

        if (!rst_n)
        begin
            for (i = 0; i < FRAME_LEN; i++)
                rx_window[i] = '0;
            fill     = 0;
            pan_off  = 0;
            tilt_off = 0;
            tx_beats_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAN_OFFSET:  pan_off  = $signed(cfg_data);
                    REG_TILT_OFFSET: tilt_off = $signed(cfg_data);
                endcase
            end
            if (in_valid && !in_stall)
                accept_rx_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                if (tx_beats_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected output transfer: byte %02h last %0d kind %0d angle %0d",
                                 $realtime, tx_byte, last_byte, angle_kind, angle_value);
                end
                else
                begin
                    want = tx_beats_due.pop_front();
                    if (tx_byte !== want.tx || last_byte !== want.last ||
                        angle_kind !== want.kind || angle_value !== want.angle)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: output mismatch: want byte %02h last %0d kind %0d angle %0d, got byte %02h last %0d kind %0d angle %0d",
                                     $realtime, want.tx, want.last, want.kind, want.angle,
                                     tx_byte, last_byte, angle_kind, angle_value);
                    end
                end
            end
            pending <= tx_beats_due.size();
        end
    end

endmodule

/* verif/pelco_d_position_rewriter_tb.sv */
// Top of the Pelco-D position rewriter testbench: clock, reset, byte stream,
// offset writes and output stalls. Depends on pdpr_pkg, the block and
// pelco_d_position_rewriter_checker, which does all prediction and comparison.
module pelco_d_position_rewriter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdpr_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_HOLD      = 300;
    localparam int NUM_PHASES     = 8;
    localparam int PRESSURE_PHASE = 2;
    localparam int TIMEOUT_CYCLES = 200000;

    localparam int FLAW_NONE = 0;
    localparam int FLAW_SUM  = 1;
    localparam int FLAW_SYNC = 2;

    // Pelco-D pan position query; any non-response command passes through.
    localparam byte_t CMD_QUERY_PAN = 8'h51;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    byte_t                      rx_byte;
    logic                       out_valid;
    logic                       out_stall;
    byte_t                      tx_byte;
    logic                       last_byte;
    logic [KIND_W-1:0]          angle_kind;
    logic signed [ANGLE_W-1:0]  angle_value;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [OFFSET_W-1:0]        cfg_data;

    logic hold_req;
    logic steady;
    int   burst_left;
    int   mismatches;
    int   pending;

    pelco_d_position_rewriter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte),
        .angle_kind  (angle_kind),
        .angle_value (angle_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    pelco_d_position_rewriter_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte),
        .angle_kind  (angle_kind),
        .angle_value (angle_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: random stall segments, plus one long hold on request.
    initial
    begin : rx_side
        int  seg_left;
        int  stall_pct;
        int  hold_left;
        bit  held;

        out_stall = 1'b0;
        seg_left  = 0;
        stall_pct = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(1, 60);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // One input transfer; bursts of back-to-back bytes are split by random gaps.
    task automatic send_byte(input byte_t b);
        int gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_frame(input byte_t addr, input byte_t cmd,
                              input logic [15:0] raw, input int flaw);
        byte_t frame [FRAME_LEN];
        int    i;

        frame[0] = SYNC_BYTE;
        frame[1] = addr;
        frame[2] = 8'($urandom);
        frame[3] = cmd;
        frame[4] = raw[15:8];
        frame[5] = raw[7:0];
        frame[6] = frame[1] + frame[2] + frame[3] + frame[4] + frame[5];
        if (flaw == FLAW_SUM)
            frame[6] = frame[6] ^ 8'($urandom_range(1, 255));
        else if (flaw == FLAW_SYNC)
            frame[0] = 8'($urandom_range(0, 254));
        for (i = 0; i < FRAME_LEN; i++)
            send_byte(frame[i]);
    endtask

    // Angles near the wrap points and the ends of the 16-bit field, or random ones.
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 8))
                    0:       return 16'd0;
                    1:       return 16'd1;
                    2:       return 16'd17999;
                    3:       return 16'd18000;
                    4:       return 16'd18001;
                    5:       return 16'd35999;
                    6:       return 16'd36000;
                    7:       return 16'd36001;
                    default: return 16'd65535;
                endcase
            end
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, 36000));
        endcase
    endfunction

    // Mostly well-formed frames with random content, some broken ones and noise.
    task automatic send_stream(input int n);
        int    sent;
        int    pick;
        int    cnt;
        int    flaw;
        byte_t cmd;

        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                cnt = $urandom_range(1, 5);
                repeat (cnt) send_byte(8'($urandom));
                sent += cnt;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    cmd = CMD_PAN_RESP;
                    2, 3:    cmd = CMD_TILT_RESP;
                    default: cmd = 8'($urandom);
                endcase
                if (pick < 25)
                    flaw = $urandom_range(0, 1) ? FLAW_SUM : FLAW_SYNC;
                else
                    flaw = FLAW_NONE;
                send_frame(8'($urandom), cmd, pick_raw(), flaw);
                sent += FRAME_LEN;
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_offsets(input int pan, input int tilt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PAN_OFFSET;
        cfg_data  <= OFFSET_W'(pan);
        @(posedge clk);
        cfg_index <= REG_TILT_OFFSET;
        cfg_data  <= OFFSET_W'(tilt);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int phase;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PAN_OFFSET;
        cfg_data   = '0;
        hold_req   = 1'b0;
        steady     = 1'b0;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, with both offsets at their reset value: pan near the top of
        // the turn, tilt just past the half turn, a pass-through command and a
        // frame whose checksum is wrong.
        send_frame(8'h01, CMD_PAN_RESP, 16'd35999, FLAW_NONE);
        send_frame(8'hFF, CMD_TILT_RESP, 16'd18001, FLAW_NONE);
        send_frame(8'h00, CMD_QUERY_PAN, 16'hFFFF, FLAW_NONE);
        send_frame(8'h02, CMD_TILT_RESP, 16'd0, FLAW_SUM);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       set_offsets(-36000, 36000);
                1:       set_offsets(36000, -36000);
                2:       set_offsets(-65536, 65535);
                3:       set_offsets(65535, -65536);
                4:       set_offsets(0, 0);
                default: set_offsets($urandom_range(0, 72000) - 36000,
                                     $urandom_range(0, 72000) - 36000);
            endcase
            if (phase == PRESSURE_PHASE)
            begin
                // Keep offering bytes while the output is held off so that the
                // block backs up and stalls its input.
                steady   = 1'b1;
                hold_req <= 1'b1;
                send_stream(60);
                steady   = 1'b0;
            end
            else
                send_stream(36);
        end

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
